// ===== hdl/knnfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnfp_pkg
// Shared types and constants for the k-nearest fingerprint locator.
// ----------------------------------------------------------------------------
package knnfp_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int K_MAX_DEF       = 16;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 8;
  localparam int MAC_W     = 48;
  localparam int SIG_W     = 8;
  localparam int COORD_W   = 10;
  localparam int DIST_W    = 8;
  localparam int CNT_W     = 5;
  localparam int K_CFG_W   = 5;
  localparam int EC_CFG_W  = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = 1'b1;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [SIG_W-1:0]   sig;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tbl_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/knnfp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnfp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module knnfp_div #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic              ge;

  always_comb begin
    trial = {rem_r, q_r[NUM_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== hdl/knn_fingerprint_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_fingerprint_locator
// k-nearest radio fingerprint locator: fingerprint table in a synchronous
// memory, sorted list of nearest matches, averaged position on finish.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in   in_tvalid/in_tready  in_tdata, in_tuser (command)
//   out      out  out_tvalid/out_tready out_tdata, out_tuser (no_match)
//
// load word: written straight into the table. observe word: scans up to
// min(entry_count, TABLE_DEPTH) entries, one table memory read per cycle.
// finish word: an accumulate pass over the list, then the bit-serial divider
// (the divider is skipped with no match).
// reset is synchronous, active low; the table holds garbage until loaded.
// one word is worked on at a time; a finished result waits in the output
// register while the next load or observe word is taken.
// ----------------------------------------------------------------------------
module knn_fingerprint_locator
  import knnfp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int K_MAX       = K_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[7:0], station_mac[55:8], signal_dbm[63:56], pos_x[73:64],
  // pos_y[83:74], zero[87:84]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // avg_x[9:0], avg_y[19:10], used_count[24:20], zero[31:25]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // no_match[0]
  output logic [0:0]            out_tuser
);

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_W = $clog2(TABLE_DEPTH + 1);
  localparam int FILL_W = $clog2(K_MAX + 1);
  localparam int SUM_W  = COORD_W + $clog2(K_MAX + 1);

  // input fields
  logic [IDX_W-1:0]   in_idx;
  logic [MAC_W-1:0]   in_mac;
  logic [SIG_W-1:0]   in_sig;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic               in_acc;

  assign in_idx = in_tdata[7:0];
  assign in_mac = in_tdata[55:8];
  assign in_sig = in_tdata[63:56];
  assign in_x   = in_tdata[73:64];
  assign in_y   = in_tdata[83:74];
  assign in_acc = in_tvalid && in_tready;

  // configuration
  logic [K_CFG_W-1:0]  cfg_k_r;
  logic [EC_CFG_W-1:0] cfg_ec_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r  <= K_CFG_W'(3);
      cfg_ec_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEIGHBOR_COUNT: cfg_k_r  <= cfg_data[K_CFG_W-1:0];
        REG_ENTRY_COUNT:    cfg_ec_r <= cfg_data[EC_CFG_W-1:0];
        default:            ;
      endcase
    end
  end

  // state
  state_t state_r, state_nxt;

  logic [MAC_W-1:0]  obs_mac_r;
  logic [SIG_W-1:0]  obs_sig_r;
  logic [SCAN_W-1:0] lim_r, lim_nxt;
  logic [SCAN_W-1:0] scan_r;
  logic              rd_vld_r;
  tbl_entry_t        rd_data_r;
  logic              hit_vld_r;
  logic [DIST_W-1:0] hit_dist_r;
  logic [COORD_W-1:0] hit_x_r, hit_y_r;

  logic [DIST_W-1:0]  near_d_r [K_MAX];
  logic [COORD_W-1:0] near_x_r [K_MAX];
  logic [COORD_W-1:0] near_y_r [K_MAX];
  logic [FILL_W-1:0]  fill_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sumi_r;
  logic [SUM_W-1:0] sum_x_r, sum_y_r;

  logic              out_vld_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_nm_r;

  // control decodes
  logic scan_issue;
  logic sum_step;
  logic div_start;
  logic emit_load;
  logic div_done;
  logic div_done_x, div_done_y;
  logic [SUM_W-1:0] quo_x, quo_y;

  logic is_load, is_obs, is_fin;

  assign is_load = in_acc && (in_tuser == CMD_LOAD);
  assign is_obs  = in_acc && (in_tuser == CMD_OBSERVE);
  assign is_fin  = in_acc && (in_tuser == CMD_FINISH);

  always_comb begin
    if (32'(cfg_ec_r) > 32'(TABLE_DEPTH)) begin
      lim_nxt = SCAN_W'(TABLE_DEPTH);
    end else begin
      lim_nxt = SCAN_W'(cfg_ec_r);
    end
  end

  always_comb begin
    int unsigned kk;
    int unsigned cc;
    kk = (32'(cfg_k_r) > 32'(K_MAX)) ? 32'(K_MAX) : 32'(cfg_k_r);
    cc = (kk < 32'(fill_r)) ? kk : 32'(fill_r);
    cnt_nxt = CNT_W'(cc);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_obs) begin
          state_nxt = ST_SCAN;
        end else if (is_fin) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SCAN: begin
        if (scan_r >= lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !hit_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (sumi_r == '0) begin
          state_nxt = (cnt_r != '0) ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    scan_issue = 1'b0;
    sum_step   = 1'b0;
    div_start  = 1'b0;
    emit_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready  = 1'b1;
      ST_SCAN:  scan_issue = (scan_r < lim_r);
      ST_DRAIN: ;
      ST_SUM: begin
        sum_step  = (sumi_r != '0);
        div_start = (sumi_r == '0) && (cnt_r != '0);
      end
      ST_DIV:   ;
      ST_EMIT:  emit_load = !out_vld_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // fingerprint table
  tbl_entry_t tbl_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (is_load && (32'(in_idx) < 32'(TABLE_DEPTH))) begin
      tbl_mem[AW'(in_idx)] <= '{mac: in_mac, sig: in_sig, x: in_x, y: in_y};
    end
    rd_data_r <= tbl_mem[AW'(scan_r)];
  end

  // scan pipeline
  logic signed [SIG_W:0] diff;
  logic [SIG_W:0]        mag;

  always_comb begin
    diff = $signed({rd_data_r.sig[SIG_W-1], rd_data_r.sig})
         - $signed({obs_sig_r[SIG_W-1], obs_sig_r});
    mag  = diff[SIG_W] ? (SIG_W+1)'(-diff) : (SIG_W+1)'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      hit_vld_r <= 1'b0;
      scan_r    <= '0;
    end else begin
      rd_vld_r  <= scan_issue;
      hit_vld_r <= rd_vld_r && (rd_data_r.mac == obs_mac_r);
      if (is_obs) begin
        scan_r <= '0;
      end else if (scan_issue) begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_obs) begin
      obs_mac_r <= in_mac;
      obs_sig_r <= in_sig;
      lim_r     <= lim_nxt;
    end
    hit_dist_r <= mag[DIST_W-1:0];
    hit_x_r    <= rd_data_r.x;
    hit_y_r    <= rd_data_r.y;
  end

  // sorted nearest list, one insertion cell per slot
  logic [K_MAX-1:0]   keep;
  logic [DIST_W-1:0]  ins_d [K_MAX];
  logic [COORD_W-1:0] ins_x [K_MAX];
  logic [COORD_W-1:0] ins_y [K_MAX];

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      keep[i] = (32'(i) < 32'(fill_r)) && (near_d_r[i] <= hit_dist_r);
    end
    for (int i = 0; i < K_MAX; i++) begin
      if (keep[i]) begin
        ins_d[i] = near_d_r[i];
        ins_x[i] = near_x_r[i];
        ins_y[i] = near_y_r[i];
      end else if ((i > 0) && !keep[(i > 0) ? i - 1 : 0]) begin
        ins_d[i] = near_d_r[(i > 0) ? i - 1 : 0];
        ins_x[i] = near_x_r[(i > 0) ? i - 1 : 0];
        ins_y[i] = near_y_r[(i > 0) ? i - 1 : 0];
      end else begin
        ins_d[i] = hit_dist_r;
        ins_x[i] = hit_x_r;
        ins_y[i] = hit_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit_vld_r) begin
      for (int i = 0; i < K_MAX; i++) begin
        near_d_r[i] <= ins_d[i];
        near_x_r[i] <= ins_x[i];
        near_y_r[i] <= ins_y[i];
      end
    end else if (sum_step) begin
      // list is consumed by shifting toward slot zero
      for (int i = 0; i < K_MAX - 1; i++) begin
        near_d_r[i] <= near_d_r[i+1];
        near_x_r[i] <= near_x_r[i+1];
        near_y_r[i] <= near_y_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (is_fin) begin
      fill_r <= '0;
    end else if (hit_vld_r && (32'(fill_r) < 32'(K_MAX))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // accumulate and divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sumi_r <= '0;
    end else if (is_fin) begin
      sumi_r <= cnt_nxt;
    end else if (sum_step) begin
      sumi_r <= sumi_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_fin) begin
      cnt_r   <= cnt_nxt;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (sum_step) begin
      sum_x_r <= sum_x_r + SUM_W'(near_x_r[0]);
      sum_y_r <= sum_y_r + SUM_W'(near_y_r[0]);
    end
  end

  knnfp_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_x_r),
    .den   (cnt_r),
    .done  (div_done_x),
    .quo   (quo_x)
  );

  knnfp_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_y_r),
    .den   (cnt_r),
    .done  (div_done_y),
    .quo   (quo_y)
  );

  assign div_done = div_done_x && div_done_y;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_cnt_r <= cnt_r;
      out_nm_r  <= (cnt_r == '0);
      out_x_r   <= (cnt_r == '0) ? '0 : quo_x[COORD_W-1:0];
      out_y_r   <= (cnt_r == '0) ? '0 : quo_y[COORD_W-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_y_r, out_x_r};
  assign out_tuser  = out_nm_r;

endmodule
